// File: hw/rtl/pcxrle_pkg.sv
// shared types and constants of the pcx run-length decoder
package pcxrle_pkg;

  localparam int unsigned PIX_CNT_W = 25;
  localparam int unsigned RUN_W     = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [BYTE_W-1:0]    RUN_BASE           = 8'd192;
  localparam logic [PIX_CNT_W-1:0] IMAGE_PIXELS_RESET = 25'd1;

  // register word index, taken from paddr[2]
  localparam logic REG_IMAGE_PIXELS = 1'b0;

  typedef enum logic {
    ST_ACCEPT,
    ST_RUN
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic run_start;
    logic run_final;
  } dp_sts_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              pixel_valid;
    logic              run_last;
    logic              image_done;
    logic              overrun;
  } pix_result_t;

endpackage

// File: hw/rtl/pcxrle_if.sv
// stream interfaces for coded bytes in and decoded pixels out
interface pcxrle_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       start_image;

  modport source (output valid, output code_byte, output start_image, input ready);
  modport sink (input valid, input code_byte, input start_image, output ready);
endinterface

interface pcxrle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       pixel_valid;
  logic       run_last;
  logic       image_done;
  logic       overrun;

  modport source (output valid, output pixel, output pixel_valid, output run_last,
                  output image_done, output overrun, input ready);
  modport sink (input valid, input pixel, input pixel_valid, input run_last,
                input image_done, input overrun, output ready);
endinterface

// File: hw/rtl/pcxrle_regs.sv
// apb configuration register holding the image size
module pcxrle_regs
  import pcxrle_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  output logic [PIX_CNT_W-1:0] image_pixels_o
);

  logic [PIX_CNT_W-1:0] image_pixels_q, image_pixels_d;
  logic                 sel_image;

  assign pready    = 1'b1;
  assign sel_image = (paddr[2] == REG_IMAGE_PIXELS);

  always_comb begin
    image_pixels_d = image_pixels_q;
    if (psel && penable && pwrite && sel_image) begin
      image_pixels_d = pwdata[PIX_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_pixels_q <= IMAGE_PIXELS_RESET;
    end else begin
      image_pixels_q <= image_pixels_d;
    end
  end

  assign prdata = sel_image ? {{(PDATA_W-PIX_CNT_W){1'b0}}, image_pixels_q} : '0;
  assign image_pixels_o = image_pixels_q;

endmodule

// File: hw/rtl/pcxrle_dp.sv
// decoder datapath: pixel counter, run state and output register
module pcxrle_dp
  import pcxrle_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  input  logic [BYTE_W-1:0]    code_byte_i,
  input  logic                 start_image_i,
  input  logic [PIX_CNT_W-1:0] image_pixels_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output pix_result_t          result_o
);

  logic [PIX_CNT_W-1:0] left_q, left_d;
  logic [RUN_W-1:0]     cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic                 stop_q, stop_d;
  logic [RUN_W-1:0]     rem_q, rem_d;
  logic                 out_valid_q, out_valid_d;
  pix_result_t          res_q, res_d;
  logic [BYTE_W-1:0]    run_pix_q, run_pix_d;
  logic                 done_flag_q, done_flag_d;

  logic [PIX_CNT_W-1:0] left_eff, n_ext, left_run, left_lit;
  logic                 pend_eff, stop_eff, over, run_final;
  logic [BYTE_W-1:0]    run_delta;

  assign left_eff  = start_image_i ? image_pixels_i : left_q;
  assign pend_eff  = start_image_i ? 1'b0 : pend_q;
  assign stop_eff  = start_image_i ? (image_pixels_i == '0) : stop_q;
  assign n_ext     = {{(PIX_CNT_W-RUN_W){1'b0}}, cnt_q};
  assign over      = n_ext > left_eff;
  assign left_run  = left_eff - n_ext;
  assign left_lit  = left_eff - {{(PIX_CNT_W-1){1'b0}}, 1'b1};
  assign run_delta = code_byte_i - RUN_BASE;
  assign run_final = (rem_q == {{(RUN_W-1){1'b0}}, 1'b1});

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.run_start = !stop_eff && pend_eff && !over
                           && (cnt_q > {{(RUN_W-1){1'b0}}, 1'b1});
  assign sts_o.run_final = run_final;

  always_comb begin
    left_d      = left_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    stop_d      = stop_q;
    rem_d       = rem_q;
    res_d       = res_q;
    run_pix_d   = run_pix_q;
    done_flag_d = done_flag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.accept) begin
      if (start_image_i) begin
        left_d = image_pixels_i;
        pend_d = 1'b0;
        cnt_d  = '0;
        stop_d = stop_eff;
      end
      if (!stop_eff) begin
        if (pend_eff) begin
          pend_d = 1'b0;
          cnt_d  = '0;
          if (over) begin
            res_d       = '{pixel: '0, pixel_valid: 1'b0, run_last: 1'b1,
                            image_done: 1'b0, overrun: 1'b1};
            out_valid_d = 1'b1;
            stop_d      = 1'b1;
          end else begin
            left_d      = left_run;
            stop_d      = (left_run == '0);
            done_flag_d = (left_run == '0);
            run_pix_d   = code_byte_i;
            rem_d       = cnt_q - {{(RUN_W-1){1'b0}}, 1'b1};
            res_d       = '{pixel: code_byte_i, pixel_valid: 1'b1,
                            run_last: (cnt_q == {{(RUN_W-1){1'b0}}, 1'b1}),
                            image_done: (cnt_q == {{(RUN_W-1){1'b0}}, 1'b1})
                                        && (left_run == '0),
                            overrun: 1'b0};
            out_valid_d = 1'b1;
          end
        end else if (code_byte_i <= RUN_BASE) begin
          left_d      = left_lit;
          stop_d      = (left_lit == '0);
          res_d       = '{pixel: code_byte_i, pixel_valid: 1'b1, run_last: 1'b1,
                          image_done: (left_lit == '0), overrun: 1'b0};
          out_valid_d = 1'b1;
        end else begin
          pend_d = 1'b1;
          cnt_d  = run_delta[RUN_W-1:0];
        end
      end
    end
    if (cmd_i.emit) begin
      rem_d       = rem_q - {{(RUN_W-1){1'b0}}, 1'b1};
      res_d       = '{pixel: run_pix_q, pixel_valid: 1'b1, run_last: run_final,
                      image_done: run_final && done_flag_q, overrun: 1'b0};
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      stop_q      <= 1'b1;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      stop_q      <= stop_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    run_pix_q   <= run_pix_d;
    done_flag_q <= done_flag_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

`ifndef SYNTHESIS
  a_emit_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> rem_q != '0)
    else $error("run pixel emitted with no pixels left in the run");

  a_run_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && sts_o.run_start |=> rem_q != '0)
    else $error("multi-pixel run started without a remaining count");

  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept || cmd_i.emit) && out_valid_d && res_d.image_done |=> stop_q)
    else $error("image finished but decoder not stopped");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.accept && cmd_i.emit))
    else $error("item accepted while a run is being emitted");
`endif

endmodule

// File: hw/rtl/pcxrle_ctrl.sv
// decoder controller: accepts bytes or steps through a run
module pcxrle_ctrl
  import pcxrle_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCEPT: begin
        if (in_valid_i && sts_i.out_free && sts_i.run_start) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.out_free && sts_i.run_final) begin
          state_d = ST_ACCEPT;
        end
      end
      default: state_d = ST_ACCEPT;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.emit   = 1'b0;
    case (state_q)
      ST_ACCEPT: begin
        in_ready_o   = sts_i.out_free;
        cmd_o.accept = in_valid_i && sts_i.out_free;
      end
      ST_RUN: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/pcxrle_decoder_top.sv
// top level of the pcx run-length decoder
// Decodes run-length coded 8-bit pixel bytes: the pixel byte of a run of n pixels holds the
// input until the last pixel of the run is emitted, while the single output register emits
// one pixel per cycle whenever the receiver reads it. A new byte is taken only when the output
// register is empty or is read in the same cycle, so a stalled receiver stalls the input.
// Set image_pixels over apb while idle; it takes effect at the next start_image, and
// decoding stops after the last pixel or an overrun result until the next start.
module pcx_rle_decoder_top
  import pcxrle_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  pcxrle_code_if.sink        code_i,
  pcxrle_pix_if.source       pix_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [PIX_CNT_W-1:0] image_pixels;
  dp_cmd_t              cmd;
  dp_sts_t              sts;
  pix_result_t          result;
  logic                 out_valid;
  logic                 in_ready;

  pcxrle_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .image_pixels_o (image_pixels)
  );

  pcxrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (code_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcxrle_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .code_byte_i    (code_i.code_byte),
    .start_image_i  (code_i.start_image),
    .image_pixels_i (image_pixels),
    .out_ready_i    (pix_o.ready),
    .out_valid_o    (out_valid),
    .result_o       (result)
  );

  assign code_i.ready      = in_ready;
  assign pix_o.valid       = out_valid;
  assign pix_o.pixel       = result.pixel;
  assign pix_o.pixel_valid = result.pixel_valid;
  assign pix_o.run_last    = result.run_last;
  assign pix_o.image_done  = result.image_done;
  assign pix_o.overrun     = result.overrun;

endmodule

// File: verif/pcx_rle_decoder_checker.sv
// monitor and scoreboard that predicts and checks decoded pixels of the pcx rle decoder
module pcx_rle_decoder_checker
  import pcxrle_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  pcxrle_code_if             code_mon,
  pcxrle_pix_if              pix_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o,
  output int unsigned        pixels_o,
  output int unsigned        overruns_o
);

  logic [PIX_CNT_W-1:0] cfg_pixels;
  logic [PIX_CNT_W-1:0] pixels_left;
  logic                 run_armed;
  logic [RUN_W-1:0]     run_len;
  logic                 halted;
  pix_result_t          pixel_q[$];
  int unsigned          n_bad;
  int unsigned          n_pix;
  int unsigned          n_ovr;

  function automatic pix_result_t make_pixel(input logic [BYTE_W-1:0] pix, input logic vld,
                                             input logic last, input logic done,
                                             input logic ovr);
    pix_result_t r;
    r.pixel       = pix;
    r.pixel_valid = vld;
    r.run_last    = last;
    r.image_done  = done;
    r.overrun     = ovr;
    return r;
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] code, input logic start);
    logic [RUN_W-1:0] n;
    if (start) begin
      pixels_left = cfg_pixels;
      run_armed   = 1'b0;
      run_len     = '0;
      halted      = (cfg_pixels == '0);
    end
    if (halted) return;
    if (run_armed) begin
      n         = run_len;
      run_armed = 1'b0;
      run_len   = '0;
      if (PIX_CNT_W'(n) > pixels_left) begin
        pixel_q.push_back(make_pixel('0, 1'b0, 1'b1, 1'b0, 1'b1));
        halted = 1'b1;
        return;
      end
      for (int i = 1; i <= int'(n); i++) begin
        pixel_q.push_back(make_pixel(code, 1'b1, i == int'(n),
                                     (i == int'(n)) && (PIX_CNT_W'(n) == pixels_left), 1'b0));
      end
      pixels_left = pixels_left - PIX_CNT_W'(n);
      halted      = (pixels_left == '0);
    end else if (code <= RUN_BASE) begin
      pixels_left = pixels_left - 1'b1;
      pixel_q.push_back(make_pixel(code, 1'b1, 1'b1, pixels_left == '0, 1'b0));
      halted = (pixels_left == '0);
    end else begin
      run_armed = 1'b1;
      run_len   = RUN_W'(code - RUN_BASE);
    end
  endtask

  task automatic check_pixel(input pix_result_t got);
    pix_result_t want;
    if (got.pixel_valid) n_pix++;
    if (got.overrun) n_ovr++;
    if (pixel_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) begin
        $display("unexpected item: pix=%02h valid=%0b last=%0b done=%0b ovr=%0b",
                 got.pixel, got.pixel_valid, got.run_last, got.image_done, got.overrun);
      end
      return;
    end
    want = pixel_q.pop_front();
    if (got.pixel !== want.pixel || got.pixel_valid !== want.pixel_valid ||
        got.run_last !== want.run_last || got.image_done !== want.image_done ||
        got.overrun !== want.overrun) begin
      n_bad++;
      if (n_bad <= 10) begin
        $display("mismatch: expected pix=%02h valid=%0b last=%0b done=%0b ovr=%0b",
                 want.pixel, want.pixel_valid, want.run_last, want.image_done, want.overrun);
        $display("          actual   pix=%02h valid=%0b last=%0b done=%0b ovr=%0b",
                 got.pixel, got.pixel_valid, got.run_last, got.image_done, got.overrun);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pixels = IMAGE_PIXELS_RESET;
      pixels_left = '0;
      run_armed = 1'b0;
      run_len = '0;
      halted = 1'b1;
      pixel_q.delete();
      n_bad = 0;
      n_pix = 0;
      n_ovr = 0;
      mismatches_o <= 0;
      pending_o <= 0;
      pixels_o <= 0;
      overruns_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_IMAGE_PIXELS) begin
        cfg_pixels = pwdata[PIX_CNT_W-1:0];
      end
      if (code_mon.valid && code_mon.ready) begin
        decode_byte(code_mon.code_byte, code_mon.start_image);
      end
      if (pix_mon.valid && pix_mon.ready) begin
        check_pixel({pix_mon.pixel, pix_mon.pixel_valid, pix_mon.run_last,
                     pix_mon.image_done, pix_mon.overrun});
      end
      mismatches_o <= n_bad;
      pending_o <= pixel_q.size();
      pixels_o <= n_pix;
      overruns_o <= n_ovr;
    end
  end

endmodule

// File: verif/pcx_rle_decoder_top_tb.sv
// testbench top: stimulus, apb setup and verdict for the pcx rle decoder
module pcx_rle_decoder_top_tb;
  import pcxrle_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IMAGE_CAP    = 120;
  localparam logic [PIX_CNT_W-1:0] MAX_PIXELS = 25'd16777216;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned pixels_seen;
  int unsigned overruns_seen;
  int unsigned code_gap_pct;
  int unsigned pix_stall_pct;
  int unsigned hold_tag;
  int unsigned cycles = 0;
  int unsigned directed_items;
  int unsigned random_items;
  int unsigned images_sent;

  pcxrle_code_if code_bus ();
  pcxrle_pix_if  pix_bus ();

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pcx_rle_decoder_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .code_i  (code_bus),
    .pix_o   (pix_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pcx_rle_decoder_checker pix_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_mon     (code_bus),
    .pix_mon      (pix_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .pixels_o     (pixels_seen),
    .overruns_o   (overruns_seen)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // pixel receiver with random stalls and an occasional long hold-off
  initial begin
    int unsigned hold_left;
    int unsigned tag_seen;
    hold_left = 0;
    tag_seen = 0;
    pix_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_tag != tag_seen) begin
        tag_seen = hold_tag;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_bus.ready <= 1'b0;
      end else begin
        pix_bus.ready <= ($urandom_range(99) >= pix_stall_pct);
      end
    end
  end

  task automatic send_code(input logic [BYTE_W-1:0] code, input logic start);
    while ($urandom_range(99) < code_gap_pct) begin
      code_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    code_bus.valid <= 1'b1;
    code_bus.code_byte <= code;
    code_bus.start_image <= start;
    @(posedge clk_i);
    while (!code_bus.ready) @(posedge clk_i);
  endtask

  task automatic settle_decoder();
    code_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_image_pixels(input logic [PIX_CNT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({REG_IMAGE_PIXELS, 2'b00});
    pwdata <= {7'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_image();
    logic [PIX_CNT_W-1:0] size;
    int unsigned          rem;
    int unsigned          n;
    int unsigned          sent;
    int unsigned          pick;
    logic                 first;
    case (images_sent % 4)
      0: begin code_gap_pct = 0;  pix_stall_pct <= 0;  end
      1: begin code_gap_pct = 53; pix_stall_pct <= 0;  end
      2: begin code_gap_pct = 0;  pix_stall_pct <= 53; end
      default: begin code_gap_pct = 10; pix_stall_pct <= 10; end
    endcase
    pick = $urandom_range(99);
    if (pick < 65) size = PIX_CNT_W'($urandom_range(1, 40));
    else if (pick < 93) size = PIX_CNT_W'($urandom_range(41, 400));
    else if (pick < 97) size = PIX_CNT_W'($urandom_range(401, 5000));
    else if (pick < 99) size = PIX_CNT_W'($urandom_range(5001, MAX_PIXELS));
    else size = MAX_PIXELS;
    settle_decoder();
    write_image_pixels(size);
    images_sent++;
    rem = size;
    first = 1'b1;
    sent = 0;
    if ($urandom_range(99) < 15) begin
      // noise: random bytes with stray restarts
      repeat ($urandom_range(5, 15)) begin
        send_code(8'($urandom), first | ($urandom_range(99) < 10));
        first = 1'b0;
        random_items++;
      end
      return;
    end
    while (rem > 0 && sent < IMAGE_CAP && random_items < RANDOM_ITEMS) begin
      if ($urandom_range(1) == 0) begin
        send_code(8'($urandom_range(0, RUN_BASE)), first);
        first = 1'b0;
        rem--;
        sent++;
        random_items++;
      end else begin
        if (rem < 63 && $urandom_range(99) < 8) n = $urandom_range(rem + 1, 63);
        else n = $urandom_range(1, (rem < 63) ? rem : 63);
        send_code(8'(RUN_BASE + n), first);
        first = 1'b0;
        sent++;
        random_items++;
        if ($urandom_range(99) < 4) begin
          // restart in the middle of a run
          first = 1'b1;
          rem = size;
        end else begin
          send_code(8'($urandom), 1'b0);
          sent++;
          random_items++;
          rem = (n > rem) ? 0 : rem - n;
        end
      end
    end
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 3)) begin
        send_code(8'($urandom), 1'b0);
        random_items++;
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    code_bus.valid <= 1'b0;
    code_bus.code_byte <= '0;
    code_bus.start_image <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_tag <= 0;
    pix_stall_pct <= 0;
    code_gap_pct = 0;
    directed_items = 0;
    random_items = 0;
    images_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle after reset, then a one-pixel image at the reset size
    send_code(8'h05, 1'b0);
    send_code(8'h00, 1'b1);
    send_code(8'hFF, 1'b0);
    settle_decoder();
    // zero image size
    write_image_pixels('0);
    send_code(8'h07, 1'b1);
    send_code(8'h0A, 1'b0);
    settle_decoder();
    // literal at run base, short run, restart mid-run, overrun, ignored tail
    write_image_pixels(25'd10);
    send_code(RUN_BASE, 1'b1);
    send_code(8'hC1, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(8'hC8, 1'b1);
    send_code(8'h80, 1'b0);
    send_code(8'hC5, 1'b0);
    send_code(8'h11, 1'b0);
    send_code(8'h33, 1'b0);
    settle_decoder();
    // longest run while the receiver holds off
    write_image_pixels(MAX_PIXELS);
    hold_tag <= hold_tag + 1;
    send_code(8'hFF, 1'b1);
    send_code(8'h00, 1'b0);
    send_code(8'h3C, 1'b0);
    send_code(8'h6B, 1'b0);
    settle_decoder();
    // a run that ends the image exactly
    write_image_pixels(25'd3);
    send_code(8'hC3, 1'b1);
    send_code(8'hAA, 1'b0);
    settle_decoder();
    write_image_pixels(25'd1);
    send_code(8'h7F, 1'b1);
    directed_items = 21;

    while (random_items < RANDOM_ITEMS) run_image();

    settle_decoder();
    $display("covered %0d directed and %0d random code bytes over %0d random images",
             directed_items, random_items, images_sent);
    $display("compared %0d pixels and %0d overrun items, %0d mismatches",
             pixels_seen, overruns_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
